>>> design/vtp_pkg.sv
// Shared types and constants of the VT100 escape sequence parser.
// Used by the palette registers, the controller, the datapath and the top level.
// No dependencies.
package vtp_pkg;

    localparam int BYTE_W      = 8;
    localparam int ACT_W       = 4;
    localparam int ARG_W       = 16;
    localparam int COLOUR_W    = 24;
    localparam int NUM_COLOURS = 8;
    localparam int CIDX_W      = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int TDATA_W     = 2 * ARG_W + COLOUR_W;

    // Display action codes.
    localparam logic [ACT_W-1:0] ACT_TEXT      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_NEWLINE   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_RETURN    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_BACKSPACE = 4'd3;
    localparam logic [ACT_W-1:0] ACT_CURSOR    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_CLRLINE   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_CLRSCREEN = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ALTBUF    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_FG        = 4'd8;
    localparam logic [ACT_W-1:0] ACT_BG        = 4'd9;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LBRKT = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_CMD_H = 8'h48;
    localparam logic [BYTE_W-1:0] CH_CMD_J = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_CMD_M = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_CMD_SET = 8'h68;
    localparam logic [BYTE_W-1:0] CH_CMD_RST = 8'h6C;

    // Parameter values with a meaning of their own.
    localparam int SGR_FG_LO   = 30;
    localparam int SGR_FG_HI   = 37;
    localparam int SGR_BG_LO   = 40;
    localparam int SGR_BG_HI   = 47;
    localparam int ALTBUF_MODE = 1047;
    localparam int ED_SCREEN   = 2;
    localparam int CURSOR_ARGS = 2;

    localparam logic [COLOUR_W-1:0] PALETTE_RESET [NUM_COLOURS] = '{
        24'h000000, 24'h770000, 24'h007700, 24'h777700,
        24'h000077, 24'h770077, 24'h007777, 24'hAAAAAA
    };

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI,
        PH_AFTERQ,
        PH_PARAM
    } t_phase;

    typedef enum logic {
        ST_ACCEPT,
        ST_WALK
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic walk_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic sgr_start;
        logic walk_hit;
        logic walk_last;
    } t_dp_status;

endpackage

>>> design/vtp_palette.sv
// Palette register file of the escape sequence parser, written over APB.
// Depends on vtp_pkg.
module vtp_palette (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vtp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vtp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vtp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic [vtp_pkg::CIDX_W-1:0]      i_rd_idx,
    output logic [vtp_pkg::COLOUR_W-1:0]    o_rd_colour
);
    import vtp_pkg::*;

    logic [COLOUR_W-1:0] r_palette [NUM_COLOURS];
    logic [CIDX_W-1:0]   reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = {{(APB_DATA_W-COLOUR_W){1'b0}}, r_palette[reg_idx]};
    assign o_rd_colour = r_palette[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COLOURS; i++) begin
                r_palette[i] <= PALETTE_RESET[i];
            end
        end else if (psel && penable && pwrite && pready) begin
            r_palette[reg_idx] <= pwdata[COLOUR_W-1:0];
        end
    end

endmodule

>>> design/vtp_ctrl.sv
// Controller of the escape sequence parser: input handshake and the SGR walk.
// Depends on vtp_pkg.
module vtp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  vtp_pkg::t_dp_status i_status,
    output vtp_pkg::t_ctrl_cmd  o_cmd
);
    import vtp_pkg::*;

    t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCEPT: begin
                if (o_cmd.accept && i_status.sgr_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (o_cmd.walk_step && i_status.walk_last) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.walk_step = 1'b0;
        unique case (r_state)
            ST_ACCEPT: begin
                o_s_tready   = i_status.out_free;
                o_cmd.accept = i_status.out_free && i_s_tvalid;
            end
            ST_WALK: begin
                // A parameter without a colour moves on without waiting for the output.
                o_cmd.walk_step = !i_status.walk_hit || i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/vtp_datapath.sv
// Datapath of the escape sequence parser: parse state, parameter registers,
// command decode, SGR colour list and the output register. Depends on vtp_pkg.
module vtp_datapath #(
    parameter int MAX_PARAMS  = 6,
    parameter int MAX_SEQ_LEN = 16,
    parameter int PARAM_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vtp_pkg::t_ctrl_cmd             i_cmd,
    output vtp_pkg::t_dp_status            o_status,
    input  logic [vtp_pkg::BYTE_W-1:0]     i_byte,
    output logic [vtp_pkg::CIDX_W-1:0]     o_pal_idx,
    input  logic [vtp_pkg::COLOUR_W-1:0]   i_pal_colour,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [vtp_pkg::ACT_W-1:0]      o_action,
    output logic [vtp_pkg::ARG_W-1:0]      o_arg_a,
    output logic [vtp_pkg::ARG_W-1:0]      o_arg_b,
    output logic [vtp_pkg::COLOUR_W-1:0]   o_colour,
    output logic                           o_last
);
    import vtp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int SEQ_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int EXT_W = PARAM_WIDTH + ARG_W;
    localparam int PRD_W = PARAM_WIDTH + 4;

    // Parse state
    t_phase                 r_phase, n_phase;
    logic                   r_private, n_private;
    logic [PARAM_WIDTH-1:0] r_param [MAX_PARAMS];
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SEQ_W-1:0]       r_seqlen, n_seqlen;

    // SGR colour list captured at the terminator
    logic [MAX_PARAMS-1:0]  r_sgr_mask, sgr_mask;
    logic [MAX_PARAMS-1:0]  r_sgr_bg, sgr_bg;
    logic [CIDX_W-1:0]      r_sgr_idx [MAX_PARAMS];
    logic [CIDX_W-1:0]      sgr_idx [MAX_PARAMS];
    logic [IDX_W-1:0]       r_walk;
    logic [MAX_PARAMS-1:0]  above_walk;

    // Output register
    logic                   r_out_valid;
    logic [ACT_W-1:0]       r_out_action;
    logic [ARG_W-1:0]       r_out_arg_a, r_out_arg_b;
    logic [COLOUR_W-1:0]    r_out_colour;
    logic                   r_out_last;

    logic                   is_digit, is_letter;
    logic [3:0]             digit;
    logic [IDX_W-1:0]       cur_idx;
    logic [PARAM_WIDTH-1:0] cur_val, sat_val;
    logic [PRD_W-1:0]       prod;
    logic                   cnt_room;
    logic [SEQ_W-1:0]       seq_inc;
    logic [CNT_W-1:0]       argc;
    logic                   do_clear, do_digit, do_finish;
    logic                   emit;
    logic [ACT_W-1:0]       e_action;
    logic [ARG_W-1:0]       e_arg_a, e_arg_b;
    logic [EXT_W-1:0]       p0_ext, p1_ext;
    logic                   sgr_start, load_single, load_walk;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_letter = ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z)) ||
                       ((i_byte >= CH_LO_A) && (i_byte <= CH_LO_Z));
    assign digit     = i_byte[3:0];
    assign cnt_room  = r_count < CNT_W'(MAX_PARAMS);
    assign cur_idx   = r_count[IDX_W-1:0];
    assign cur_val   = r_param[cur_idx];
    assign seq_inc   = r_seqlen + 1'b1;
    assign p0_ext    = {{ARG_W{1'b0}}, r_param[0]};
    assign p1_ext    = {{ARG_W{1'b0}}, r_param[1]};

    // Times ten as two shifted copies plus the digit, then saturate.
    assign prod    = (PRD_W'(cur_val) << 3) + (PRD_W'(cur_val) << 1) + PRD_W'(digit);
    assign sat_val = (prod > PRD_W'({PARAM_WIDTH{1'b1}})) ? {PARAM_WIDTH{1'b1}}
                                                          : prod[PARAM_WIDTH-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_private = r_private;
        n_count   = r_count;
        n_seqlen  = r_seqlen;
        do_clear  = 1'b0;
        do_digit  = 1'b0;
        do_finish = 1'b0;
        argc      = '0;
        emit      = 1'b0;
        e_action  = ACT_TEXT;
        e_arg_a   = '0;
        e_arg_b   = '0;

        unique case (r_phase)
            PH_IDLE: begin
                unique case (i_byte)
                    CH_ESC: begin
                        n_phase  = PH_ESC;
                        n_seqlen = SEQ_W'(1);
                    end
                    CH_LF: begin
                        emit     = 1'b1;
                        e_action = ACT_NEWLINE;
                    end
                    CH_CR: begin
                        emit     = 1'b1;
                        e_action = ACT_RETURN;
                    end
                    CH_BS: begin
                        emit     = 1'b1;
                        e_action = ACT_BACKSPACE;
                    end
                    CH_TAB: begin
                        emit = 1'b0;
                    end
                    default: begin
                        emit     = 1'b1;
                        e_action = ACT_TEXT;
                        e_arg_a  = ARG_W'(i_byte);
                    end
                endcase
            end
            PH_ESC: begin
                n_seqlen = seq_inc;
                if (i_byte == CH_LBRKT) begin
                    n_phase = PH_CSI;
                end else begin
                    do_clear = 1'b1;
                end
            end
            PH_CSI, PH_AFTERQ: begin
                n_seqlen = seq_inc;
                if ((i_byte == CH_QUEST) && (r_phase == PH_CSI)) begin
                    n_private = 1'b1;
                    n_phase   = PH_AFTERQ;
                end else if (is_digit) begin
                    do_digit = cnt_room;
                    n_phase  = PH_PARAM;
                end else begin
                    do_finish = 1'b1;
                    argc      = '0;
                end
            end
            PH_PARAM: begin
                n_seqlen = seq_inc;
                if (is_digit) begin
                    do_digit = cnt_room;
                end else if (i_byte == CH_SEMI) begin
                    if (cnt_room) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    do_finish = 1'b1;
                    argc      = cnt_room ? r_count + 1'b1 : CNT_W'(MAX_PARAMS);
                end
            end
            default: begin
                do_clear = 1'b1;
            end
        endcase

        // Overlong sequence: dropped once a non-final byte reaches the limit.
        if ((r_phase != PH_IDLE) && !do_clear && !do_finish &&
            (seq_inc >= SEQ_W'(MAX_SEQ_LEN))) begin
            do_clear = 1'b1;
        end

        if (do_finish) begin
            do_clear = 1'b1;
            if (is_letter) begin
                if (r_private) begin
                    if (((i_byte == CH_CMD_SET) || (i_byte == CH_CMD_RST)) &&
                        (p0_ext == EXT_W'(ALTBUF_MODE))) begin
                        emit     = 1'b1;
                        e_action = ACT_ALTBUF;
                        e_arg_a  = ARG_W'(i_byte == CH_CMD_SET);
                    end
                end else if (i_byte == CH_CMD_H) begin
                    if (argc == CNT_W'(CURSOR_ARGS)) begin
                        emit     = 1'b1;
                        e_action = ACT_CURSOR;
                        e_arg_a  = p0_ext[ARG_W-1:0];
                        e_arg_b  = p1_ext[ARG_W-1:0];
                    end
                end else if (i_byte == CH_CMD_J) begin
                    if (argc == '0) begin
                        emit     = 1'b1;
                        e_action = ACT_CLRLINE;
                    end else if (p0_ext == EXT_W'(ED_SCREEN)) begin
                        emit     = 1'b1;
                        e_action = ACT_CLRSCREEN;
                    end
                end
            end
        end

        if (do_clear) begin
            n_phase   = PH_IDLE;
            n_private = 1'b0;
            n_count   = '0;
            n_seqlen  = '0;
            do_digit  = 1'b0;
        end
    end

    // Colour list of an SGR terminator: one entry per given parameter.
    always_comb begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
            logic fg_hit, bg_hit;
            fg_hit = (r_param[i] >= PARAM_WIDTH'(SGR_FG_LO)) &&
                     (r_param[i] <= PARAM_WIDTH'(SGR_FG_HI));
            bg_hit = (r_param[i] >= PARAM_WIDTH'(SGR_BG_LO)) &&
                     (r_param[i] <= PARAM_WIDTH'(SGR_BG_HI));
            sgr_mask[i] = (CNT_W'(i) <= r_count) && (fg_hit || bg_hit);
            sgr_bg[i]   = bg_hit;
            // Thirty is six modulo eight, so the foreground index is the low bits plus two.
            sgr_idx[i]  = bg_hit ? r_param[i][CIDX_W-1:0]
                                 : r_param[i][CIDX_W-1:0] + CIDX_W'(2);
        end
    end

    assign sgr_start = do_finish && is_letter && !r_private && (i_byte == CH_CMD_M) &&
                       (r_phase == PH_PARAM) && (|sgr_mask);

    always_comb begin
        for (int i = 0; i < MAX_PARAMS; i++) begin
            above_walk[i] = IDX_W'(i) > r_walk;
        end
    end

    assign o_pal_idx   = r_sgr_idx[r_walk];
    assign load_single = i_cmd.accept && emit;
    assign load_walk   = i_cmd.walk_step && r_sgr_mask[r_walk];

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.sgr_start = sgr_start;
    assign o_status.walk_hit  = r_sgr_mask[r_walk];
    assign o_status.walk_last = ~|(r_sgr_mask & above_walk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_private <= 1'b0;
            r_count   <= '0;
            r_seqlen  <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_param[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_phase   <= n_phase;
            r_private <= n_private;
            r_count   <= n_count;
            r_seqlen  <= n_seqlen;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                if (do_clear) begin
                    r_param[i] <= '0;
                end else if (do_digit && (cur_idx == IDX_W'(i))) begin
                    r_param[i] <= sat_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && sgr_start) begin
            r_sgr_mask <= sgr_mask;
            r_sgr_bg   <= sgr_bg;
            r_walk     <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_sgr_idx[i] <= sgr_idx[i];
            end
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_single || load_walk) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_single) begin
            r_out_action <= e_action;
            r_out_arg_a  <= e_arg_a;
            r_out_arg_b  <= e_arg_b;
            r_out_colour <= '0;
            r_out_last   <= 1'b1;
        end else if (load_walk) begin
            r_out_action <= r_sgr_bg[r_walk] ? ACT_BG : ACT_FG;
            r_out_arg_a  <= '0;
            r_out_arg_b  <= '0;
            r_out_colour <= i_pal_colour;
            r_out_last   <= o_status.walk_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out_action;
    assign o_arg_a     = r_out_arg_a;
    assign o_arg_b     = r_out_arg_b;
    assign o_colour    = r_out_colour;
    assign o_last      = r_out_last;

endmodule

>>> design/vt100_escape_parser_core.sv
// VT100 escape sequence parser, top level. The result of a taken byte stands in the
// output register from the next cycle; the next byte is taken once that register
// is empty or is emptied in the same cycle. An SGR 'm' terminator then walks its
// parameters, one per cycle when the receiver keeps up, and holds the input until
// the walk is done. Reset is synchronous and active low; it returns the parser to
// idle and loads the default palette.
module vt100_escape_parser_core #(
    parameter int MAX_PARAMS  = 6,
    parameter int MAX_SEQ_LEN = 16,
    parameter int PARAM_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // s_tdata: [7:0] byte_in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vtp_pkg::BYTE_W-1:0]      s_tdata,
    // m_tdata: [15:0] arg_a, [31:16] arg_b, [55:32] colour
    // m_tuser: [3:0] action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vtp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [vtp_pkg::ACT_W-1:0]       m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vtp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vtp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vtp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import vtp_pkg::*;

    t_ctrl_cmd           cmd;
    t_dp_status          status;
    logic [CIDX_W-1:0]   pal_idx;
    logic [COLOUR_W-1:0] pal_colour;
    logic [ARG_W-1:0]    arg_a, arg_b;
    logic [COLOUR_W-1:0] colour;

    vtp_palette u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_rd_idx    (pal_idx),
        .o_rd_colour (pal_colour)
    );

    vtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vtp_datapath #(
        .MAX_PARAMS  (MAX_PARAMS),
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_byte       (s_tdata),
        .o_pal_idx    (pal_idx),
        .i_pal_colour (pal_colour),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_action     (m_tuser),
        .o_arg_a      (arg_a),
        .o_arg_b      (arg_b),
        .o_colour     (colour),
        .o_last       (m_tlast)
    );

    assign m_tdata = {colour, arg_b, arg_a};

endmodule

>>> test/tb_top.sv
// Self-checking testbench for vt100_escape_parser_core: terminal bytes go in on the
// slave stream, display actions are checked against a built-in parser model.
// Depends on vtp_pkg and the parser RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vtp_pkg::*;

    localparam int MAX_PARAMS   = 6;
    localparam int MAX_SEQ_LEN  = 16;
    localparam int PARAM_WIDTH  = 16;
    localparam int unsigned PARAM_MAX = (1 << PARAM_WIDTH) - 1;
    localparam int DRAIN_CYCLES = MAX_PARAMS + 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 30;

    // Palette loads used between phases.
    localparam int PAL_RANDOM  = 0;
    localparam int PAL_ONES    = 1;
    localparam int PAL_ZERO    = 2;
    localparam int PAL_STRIPES = 3;

    typedef logic [BYTE_W-1:0] char_t;

    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [ARG_W-1:0]    arg_a;
        logic [ARG_W-1:0]    arg_b;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } display_action_t;

    class escape_scoreboard;
        logic [COLOUR_W-1:0] palette [NUM_COLOURS];
        t_phase              phase;
        bit                  private_seq;
        logic [ARG_W-1:0]    params [MAX_PARAMS];
        int                  nparams;
        int                  seq_len;
        display_action_t     pending_actions [$];
        int                  errors;
        int                  bytes_taken;
        int                  actions_checked;

        function new();
            for (int i = 0; i < NUM_COLOURS; i++) palette[i] = PALETTE_RESET[i];
            errors = 0;
            bytes_taken = 0;
            actions_checked = 0;
            clear_seq();
        endfunction

        function void set_colour(int idx, logic [COLOUR_W-1:0] value);
            palette[idx] = value;
        endfunction

        function void clear_seq();
            phase = PH_IDLE;
            private_seq = 0;
            for (int i = 0; i < MAX_PARAMS; i++) params[i] = '0;
            nparams = 0;
            seq_len = 0;
        endfunction

        function void push_action(logic [ACT_W-1:0] act, logic [ARG_W-1:0] a,
                                  logic [ARG_W-1:0] b, logic [COLOUR_W-1:0] col);
            display_action_t r;
            r.action = act;
            r.arg_a  = a;
            r.arg_b  = b;
            r.colour = col;
            r.last   = 1'b0;
            pending_actions.push_back(r);
        endfunction

        function void add_digit(int unsigned d);
            int unsigned v;
            if (nparams >= MAX_PARAMS) return;
            v = params[nparams] * 10 + d;
            params[nparams] = (v > PARAM_MAX) ? ARG_W'(PARAM_MAX) : ARG_W'(v);
        endfunction

        function void run_command(char_t c, int argc);
            int v;
            if (private_seq) begin
                if ((c == CH_CMD_SET || c == CH_CMD_RST) && params[0] == ALTBUF_MODE)
                    push_action(ACT_ALTBUF, (c == CH_CMD_SET) ? 16'd1 : 16'd0, '0, '0);
                return;
            end
            if (c == CH_CMD_H) begin
                if (argc == CURSOR_ARGS) push_action(ACT_CURSOR, params[0], params[1], '0);
            end else if (c == CH_CMD_J) begin
                if (argc == 0) push_action(ACT_CLRLINE, '0, '0, '0);
                else if (params[0] == ED_SCREEN) push_action(ACT_CLRSCREEN, '0, '0, '0);
            end else if (c == CH_CMD_M) begin
                for (int i = 0; i < argc && i < MAX_PARAMS; i++) begin
                    v = params[i];
                    if (v >= SGR_FG_LO && v <= SGR_FG_HI)
                        push_action(ACT_FG, '0, '0, palette[v - SGR_FG_LO]);
                    else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
                        push_action(ACT_BG, '0, '0, palette[v - SGR_BG_LO]);
                end
            end
        endfunction

        function void end_sequence(char_t c, int argc);
            if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z))
                run_command(c, argc);
            clear_seq();
        endfunction

        // Advances the parser model by one accepted byte and queues its actions.
        function void take_byte(char_t c);
            int prior_size;
            bit is_digit;
            prior_size = pending_actions.size();
            is_digit = (c >= CH_ZERO && c <= CH_NINE);
            bytes_taken++;
            if (phase == PH_IDLE) begin
                if (c == CH_ESC) begin
                    phase = PH_ESC;
                    seq_len = 1;
                end else if (c == CH_LF) begin
                    push_action(ACT_NEWLINE, '0, '0, '0);
                end else if (c == CH_CR) begin
                    push_action(ACT_RETURN, '0, '0, '0);
                end else if (c == CH_BS) begin
                    push_action(ACT_BACKSPACE, '0, '0, '0);
                end else if (c != CH_TAB) begin
                    push_action(ACT_TEXT, ARG_W'(c), '0, '0);
                end
            end else begin
                seq_len++;
                case (phase)
                    PH_ESC: begin
                        if (c == CH_LBRKT) phase = PH_CSI;
                        else clear_seq();
                    end
                    PH_CSI, PH_AFTERQ: begin
                        if (c == CH_QUEST && phase == PH_CSI) begin
                            private_seq = 1;
                            phase = PH_AFTERQ;
                        end else if (is_digit) begin
                            add_digit(c - CH_ZERO);
                            phase = PH_PARAM;
                        end else begin
                            end_sequence(c, 0);
                        end
                    end
                    default: begin
                        if (is_digit) begin
                            add_digit(c - CH_ZERO);
                        end else if (c == CH_SEMI) begin
                            if (nparams < MAX_PARAMS) nparams++;
                        end else begin
                            end_sequence(c, (nparams < MAX_PARAMS) ? nparams + 1 : MAX_PARAMS);
                        end
                    end
                endcase
                if (phase != PH_IDLE && seq_len >= MAX_SEQ_LEN) clear_seq();
            end
            if (pending_actions.size() > prior_size)
                pending_actions[pending_actions.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_action(logic [ACT_W-1:0] act, logic [TDATA_W-1:0] data, logic last);
            display_action_t e;
            if (pending_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected action %0d data %h", act, data));
                return;
            end
            e = pending_actions.pop_front();
            actions_checked++;
            if (act !== e.action)
                report_mismatch($sformatf("action %0d, wanted %0d", act, e.action));
            if (data[ARG_W-1:0] !== e.arg_a)
                report_mismatch($sformatf("arg_a %0d, wanted %0d", data[ARG_W-1:0], e.arg_a));
            if (data[2*ARG_W-1:ARG_W] !== e.arg_b)
                report_mismatch($sformatf("arg_b %0d, wanted %0d",
                                          data[2*ARG_W-1:ARG_W], e.arg_b));
            if (data[TDATA_W-1:2*ARG_W] !== e.colour)
                report_mismatch($sformatf("colour %h, wanted %h",
                                          data[TDATA_W-1:2*ARG_W], e.colour));
            if (last !== e.last)
                report_mismatch($sformatf("tlast %b, wanted %b", last, e.last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic [ACT_W-1:0]       m_tuser;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    escape_scoreboard sb = new();
    char_t            byte_q [$];
    int               long_hold = 0;
    bit               no_idle = 0;
    int               palette_loads = 0;

    vt100_escape_parser_core #(
        .MAX_PARAMS  (MAX_PARAMS),
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** vt100_escape_parser_core: FAILED **");
        $finish;
    end

    // Results are checked before the byte of the same edge is taken into the model.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_action(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready) sb.take_byte(s_tdata);
        end
    end

    // Receiver: random stall bursts, plus a long hold-off counted here.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task send_byte(input char_t b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task send_queued(inout int sent);
        while (byte_q.size() != 0) begin
            send_byte(byte_q.pop_front());
            sent++;
        end
    endtask

    task wait_drained();
        while (sb.pending_actions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task apb_write(input int idx, input logic [COLOUR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_colour(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task apb_readback(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(sb.palette[idx]))
            sb.report_mismatch($sformatf("palette %0d reads %h, wanted %h",
                                         idx, prdata, sb.palette[idx]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task load_palette(input int mode);
        logic [COLOUR_W-1:0] colour;
        for (int i = 0; i < NUM_COLOURS; i++) begin
            case (mode)
                PAL_ONES:    colour = '1;
                PAL_ZERO:    colour = '0;
                PAL_STRIPES: colour = i[0] ? 24'h555555 : 24'hAAAAAA;
                default:     colour = COLOUR_W'($urandom);
            endcase
            apb_write(i, colour);
        end
        for (int i = 0; i < NUM_COLOURS; i++) apb_readback(i);
        palette_loads++;
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(char_t'(s[i]));
    endtask

    task push_number(input int unsigned v);
        push_text($sformatf("%0d", v));
    endtask

    function automatic int unsigned pick_param();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return PARAM_MAX;
        if (r == 1) return PARAM_MAX + 1 + $urandom_range(0, 30000);
        if (r == 2) return $urandom_range(0, 65535);
        return $urandom_range(0, 99);
    endfunction

    function automatic char_t pick_letter();
        return $urandom_range(0, 1) ? char_t'($urandom_range(CH_UP_A, CH_UP_Z))
                                    : char_t'($urandom_range(CH_LO_A, CH_LO_Z));
    endfunction

    // Queues one random unit: mostly well-formed sequences, some noise and broken ones.
    task queue_random_unit();
        int kind;
        int n;
        char_t c;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(char_t'($urandom_range(0, 255)));
        end else if (kind < 22) begin
            case ($urandom_range(0, 3))
                0: byte_q.push_back(CH_LF);
                1: byte_q.push_back(CH_CR);
                2: byte_q.push_back(CH_BS);
                default: byte_q.push_back(CH_TAB);
            endcase
        end else if (kind < 36) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back(CH_LBRKT);
            n = $urandom_range(0, 7);
            if (n != 0) push_number(pick_param());
            if (n != 1) begin
                byte_q.push_back(CH_SEMI);
                if (n != 2) push_number(pick_param());
            end
            if (n == 3) begin
                byte_q.push_back(CH_SEMI);
                push_number(pick_param());
            end
            byte_q.push_back($urandom_range(0, 7) == 0 ? pick_letter() : CH_CMD_H);
        end else if (kind < 46) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back(CH_LBRKT);
            case ($urandom_range(0, 4))
                0: ;
                1, 2: push_number(ED_SCREEN);
                3: push_number($urandom_range(0, 5));
                default: push_text("2;5");
            endcase
            byte_q.push_back(CH_CMD_J);
        end else if (kind < 66) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back(CH_LBRKT);
            if ($urandom_range(0, 9) == 0) begin
                // More parameters than the parser keeps.
                push_text("1;2;3;4;5;6;31m");
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) byte_q.push_back(CH_SEMI);
                    case ($urandom_range(0, 7))
                        0: push_number($urandom_range(0, 99));
                        1: ;
                        2, 3, 4: push_number($urandom_range(SGR_FG_LO, SGR_FG_HI));
                        default: push_number($urandom_range(SGR_BG_LO, SGR_BG_HI));
                    endcase
                end
                byte_q.push_back(CH_CMD_M);
            end
        end else if (kind < 76) begin
            byte_q.push_back(CH_ESC);
            byte_q.push_back(CH_LBRKT);
            if ($urandom_range(0, 5) != 0) byte_q.push_back(CH_QUEST);
            if ($urandom_range(0, 7) == 0) byte_q.push_back(CH_QUEST);
            if ($urandom_range(0, 4) != 0) push_number(ALTBUF_MODE);
            else push_number(pick_param());
            case ($urandom_range(0, 4))
                0, 1: byte_q.push_back(CH_CMD_SET);
                2, 3: byte_q.push_back(CH_CMD_RST);
                default: byte_q.push_back(pick_letter());
            endcase
        end else if (kind < 86) begin
            // Around the length limit: some end in time, others are dropped.
            byte_q.push_back(CH_ESC);
            byte_q.push_back(CH_LBRKT);
            n = $urandom_range(11, 18);
            for (int i = 0; i < n; i++)
                byte_q.push_back($urandom_range(0, 3) == 0 ? CH_SEMI
                                 : char_t'($urandom_range(CH_ZERO, CH_NINE)));
            byte_q.push_back(CH_CMD_M);
        end else begin
            byte_q.push_back(CH_ESC);
            case ($urandom_range(0, 3))
                0: byte_q.push_back(char_t'($urandom_range(0, 255)));
                1: begin
                    byte_q.push_back(CH_LBRKT);
                    byte_q.push_back(CH_SEMI);
                end
                2: begin
                    byte_q.push_back(CH_LBRKT);
                    push_number($urandom_range(0, 999));
                    // Any terminator that is neither digit, ';' nor letter.
                    do c = char_t'($urandom_range(0, 255));
                    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI ||
                           (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z));
                    byte_q.push_back(c);
                end
                default: begin
                    byte_q.push_back(CH_LBRKT);
                    byte_q.push_back(pick_letter());
                end
            endcase
        end
    endtask

    task random_phase(input int target);
        int sent;
        sent = 0;
        while (sent < target) begin
            queue_random_unit();
            send_queued(sent);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int sent;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset palette.
        sent = 0;
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        push_text("A");
        byte_q.push_back(CH_LF);
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_BS);
        byte_q.push_back(CH_TAB);
        byte_q.push_back(CH_ESC);
        push_text("x");
        byte_q.push_back(CH_ESC);
        push_text("[31;47m");
        byte_q.push_back(CH_ESC);
        push_text("[J");
        byte_q.push_back(CH_ESC);
        push_text("[?1047h");
        send_queued(sent);
        random_phase(PHASE_BYTES / 2);
        wait_drained();

        load_palette(PAL_RANDOM);
        random_phase(PHASE_BYTES);
        wait_drained();

        load_palette(PAL_ONES);
        random_phase(PHASE_BYTES);
        wait_drained();

        // The receiver holds off while text keeps coming, so the input backs up.
        load_palette(PAL_ZERO);
        long_hold = HOLD_CYCLES;
        repeat (40) byte_q.push_back(char_t'($urandom_range(CH_UP_A, CH_UP_Z)));
        send_queued(sent);
        random_phase(PHASE_BYTES / 2);
        wait_drained();

        load_palette(PAL_STRIPES);
        random_phase(PHASE_BYTES / 2);
        wait_drained();

        // Last part runs at full rate on both sides.
        load_palette(PAL_RANDOM);
        no_idle = 1;
        random_phase(PHASE_BYTES);
        wait_drained();

        $display("Run covered %0d bytes and %0d checked actions over %0d palette loads,",
                 sb.bytes_taken, sb.actions_checked, palette_loads);
        $display("with stalls on both sides, one long output hold-off and a full-rate tail.");
        if (sb.errors == 0) begin
            $display("** vt100_escape_parser_core: PASSED **");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("** vt100_escape_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
